@@ rtl/upp_pkg.sv @@
// upp_pkg: shared constants, cordic result type and arctangent table
// for the unicycle pose predictor; no dependencies
`default_nettype none

package upp_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_IDX_W            = 5;
    localparam int ANG_W                 = 36;
    localparam int CRD_W                 = 34;
    localparam int ANG_SHIFT             = 18;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CRD_W-1:0] GAIN_Q30    = 34'sd652032874;

    localparam logic signed [17:0] PI_Q12     = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

    localparam logic [15:0] STEP_TIME_RST = 16'd6554;
    localparam logic [7:0]  HORIZON_RST   = 8'd20;

    localparam logic CFG_STEP_TIME = 1'b0;
    localparam logic CFG_HORIZON   = 1'b1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } t_cordic_res;

    // atan(2^-i) in q6.30, truncated
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 36'sh03243F6A8;
            5'd1:    v = 36'sh01DAC6705;
            5'd2:    v = 36'sh00FADBAFC;
            5'd3:    v = 36'sh007F56EA6;
            5'd4:    v = 36'sh003FEAB76;
            5'd5:    v = 36'sh001FFD55B;
            5'd6:    v = 36'sh000FFFAAA;
            5'd7:    v = 36'sh0007FFF55;
            5'd8:    v = 36'sh0003FFFEA;
            5'd9:    v = 36'sh0001FFFFD;
            5'd10:   v = 36'sh0000FFFFF;
            5'd11:   v = 36'sh00007FFFF;
            5'd12:   v = 36'sh00003FFFF;
            5'd13:   v = 36'sh00001FFFF;
            5'd14:   v = 36'sh00000FFFF;
            5'd15:   v = 36'sh000007FFF;
            5'd16:   v = 36'sh000003FFF;
            5'd17:   v = 36'sh000001FFF;
            5'd18:   v = 36'sh000000FFF;
            5'd19:   v = 36'sh0000007FF;
            5'd20:   v = 36'sh0000003FF;
            5'd21:   v = 36'sh0000001FF;
            5'd22:   v = 36'sh0000000FF;
            5'd23:   v = 36'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/upp_mul.sv @@
// upp_mul: shared 32x32 signed multiplier with registered product
// depends on nothing
`default_nettype none

module upp_mul (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [63:0]      o_p
);

    logic signed [63:0] r_p;
    logic signed [63:0] n_p;

    always_comb begin
        n_p = 64'(i_a) * 64'(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ rtl/upp_cordic.sv @@
// upp_cordic: iterative rotation-mode cordic, one rotation per cycle,
// with angle wrap and half-plane fold; depends on upp_pkg
`default_nettype none

module upp_cordic #(
    parameter int ITERATIONS = upp_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_angle,
    output upp_pkg::t_cordic_res    o_res
);
    import upp_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_WRAP = 3'b010,
        C_ROT  = 3'b100
    } t_cstate;

    t_cstate                 r_state, n_state;
    logic signed [ANG_W-1:0] r_z, n_z;
    logic signed [CRD_W-1:0] r_x, n_x;
    logic signed [CRD_W-1:0] r_y, n_y;
    logic [ATAN_IDX_W-1:0]   r_i, n_i;
    logic                    r_neg, n_neg;
    logic                    r_done, n_done;
    logic signed [31:0]      r_cos, n_cos;
    logic signed [31:0]      r_sin, n_sin;

    logic signed [CRD_W-1:0] w_xs, w_ys, w_nx, w_ny;
    logic signed [ANG_W-1:0] w_atan, w_nz;
    logic                    w_last;

    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = atan_q30(r_i);
    assign w_last = (r_i == ATAN_IDX_W'(ITERATIONS - 1));

    always_comb begin
        if (r_z >= 0) begin
            w_nx = r_x - w_ys;
            w_ny = r_y + w_xs;
            w_nz = r_z - w_atan;
        end else begin
            w_nx = r_x + w_ys;
            w_ny = r_y - w_xs;
            w_nz = r_z + w_atan;
        end
    end

    always_comb begin
        n_state = r_state;
        n_z     = r_z;
        n_x     = r_x;
        n_y     = r_y;
        n_i     = r_i;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_cos   = r_cos;
        n_sin   = r_sin;
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_z     = ANG_W'(i_angle) <<< ANG_SHIFT;
                    n_state = C_WRAP;
                end
            end
            C_WRAP: begin
                if (r_z > PI_Q30) begin
                    n_z = r_z - TWO_PI_Q30;
                end else if (r_z < -PI_Q30) begin
                    n_z = r_z + TWO_PI_Q30;
                end else begin
                    n_x     = GAIN_Q30;
                    n_y     = '0;
                    n_i     = '0;
                    n_neg   = 1'b0;
                    n_state = C_ROT;
                    // fold into the right half plane
                    if (r_z > HALF_PI_Q30) begin
                        n_z   = r_z - PI_Q30;
                        n_neg = 1'b1;
                    end else if (r_z < -HALF_PI_Q30) begin
                        n_z   = r_z + PI_Q30;
                        n_neg = 1'b1;
                    end
                end
            end
            C_ROT: begin
                n_x = w_nx;
                n_y = w_ny;
                n_z = w_nz;
                n_i = r_i + 1'b1;
                if (w_last) begin
                    n_cos   = r_neg ? 32'(-w_nx) : 32'(w_nx);
                    n_sin   = r_neg ? 32'(-w_ny) : 32'(w_ny);
                    n_done  = 1'b1;
                    n_state = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z   <= n_z;
        r_x   <= n_x;
        r_y   <= n_y;
        r_i   <= n_i;
        r_neg <= n_neg;
        r_cos <= n_cos;
        r_sin <= n_sin;
    end

    assign o_res = '{done: r_done, cos_v: r_cos, sin_v: r_sin};

endmodule

`default_nettype wire

@@ rtl/unicycle_pose_predictor_top.sv @@
// Unicycle pose predictor, forward-Euler. A start transfer (cmd 0) loads the
// pose and goes straight to the result stage, S_DONE. A step transfer (cmd 1)
// runs the angle wrap, one cordic rotation per cycle, five passes through the
// single shared 32x32 multiplier (speed*dt, then the x, y, heading and speed
// products), the heading wrap and the load of the output register. One item
// is in flight at a time; a new item is taken while the previous result still
// waits in the output register.
// Depends on upp_pkg, upp_cordic and upp_mul.
`default_nettype none

module unicycle_pose_predictor_top #(
    parameter int CORDIC_ITERATIONS = upp_pkg::CORDIC_ITERATIONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_cmd,
    input  wire logic signed [31:0] i_x_in,
    input  wire logic signed [31:0] i_y_in,
    input  wire logic signed [15:0] i_theta_in,
    input  wire logic signed [15:0] i_v_in,
    input  wire logic signed [15:0] i_accel,
    input  wire logic signed [15:0] i_turn_rate,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_x_out,
    output logic signed [31:0]      o_y_out,
    output logic signed [15:0]      o_theta_out,
    output logic [7:0]              o_step_index,
    output logic                    o_is_last
);
    import upp_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ROT   = 9'b000000010,
        S_MX    = 9'b000000100,
        S_MY    = 9'b000001000,
        S_MH    = 9'b000010000,
        S_MS    = 9'b000100000,
        S_MV    = 9'b001000000,
        S_HWRAP = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    localparam logic signed [63:0] POS_RND = 64'sh0000_0200_0000_0000;
    localparam logic signed [63:0] Q12_RND = 64'sh0000_0000_0000_8000;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
        logic signed [31:0] v;
        if (s[32] != s[31]) begin
            v = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            v = s[31:0];
        end
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] s);
        logic signed [15:0] v;
        if ((s[17] != s[16]) || (s[16] != s[15])) begin
            v = s[17] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            v = s[15:0];
        end
        return v;
    endfunction

    t_state             r_state, n_state;
    logic [15:0]        r_step_time, n_step_time;
    logic [7:0]         r_horizon, n_horizon;
    logic signed [31:0] r_pos_x, n_pos_x;
    logic signed [31:0] r_pos_y, n_pos_y;
    logic signed [15:0] r_heading, n_heading;
    logic signed [15:0] r_speed, n_speed;
    logic [7:0]         r_count, n_count;
    logic signed [15:0] r_acc, n_acc;
    logic signed [15:0] r_rate, n_rate;
    logic signed [31:0] r_base, n_base;
    logic signed [17:0] r_h, n_h;
    logic               r_cmd, n_cmd;
    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_x_out, n_x_out;
    logic signed [31:0] r_y_out, n_y_out;
    logic signed [15:0] r_theta_out, n_theta_out;
    logic [7:0]         r_step_idx, n_step_idx;
    logic               r_is_last, n_is_last;

    t_cordic_res        w_cres;
    logic signed [31:0] w_mul_a, w_mul_b, w_dt;
    logic signed [63:0] w_prod, w_pos_rnd, w_q12_rnd;
    logic signed [21:0] w_dpos;
    logic signed [16:0] w_dq12;
    logic               w_accept;
    logic               w_cstart;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cstart   = w_accept && (i_cmd == CMD_STEP);
    assign w_dt       = signed'({16'b0, r_step_time});

    upp_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (r_heading),
        .o_res   (w_cres)
    );

    upp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // multiplier operand select
    always_comb begin
        case (r_state)
            S_MX: begin
                w_mul_a = signed'(w_prod[31:0]);
                w_mul_b = w_cres.cos_v;
            end
            S_MY: begin
                w_mul_a = r_base;
                w_mul_b = w_cres.sin_v;
            end
            S_MH: begin
                w_mul_a = 32'(r_rate);
                w_mul_b = w_dt;
            end
            S_MS: begin
                w_mul_a = 32'(r_acc);
                w_mul_b = w_dt;
            end
            default: begin
                w_mul_a = 32'(r_speed);
                w_mul_b = w_dt;
            end
        endcase
    end

    assign w_pos_rnd = w_prod + POS_RND;
    assign w_q12_rnd = w_prod + Q12_RND;
    assign w_dpos    = signed'(w_pos_rnd[63:42]);
    assign w_dq12    = signed'(w_q12_rnd[32:16]);

    always_comb begin
        n_state     = r_state;
        n_step_time = r_step_time;
        n_horizon   = r_horizon;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_heading   = r_heading;
        n_speed     = r_speed;
        n_count     = r_count;
        n_acc       = r_acc;
        n_rate      = r_rate;
        n_base      = r_base;
        n_h         = r_h;
        n_cmd       = r_cmd;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_x_out     = r_x_out;
        n_y_out     = r_y_out;
        n_theta_out = r_theta_out;
        n_step_idx  = r_step_idx;
        n_is_last   = r_is_last;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP_TIME: n_step_time = i_cfg_data;
                CFG_HORIZON:   n_horizon   = i_cfg_data[7:0];
                default:       n_horizon   = r_horizon;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = i_cmd;
                    if (i_cmd == CMD_START) begin
                        n_pos_x   = i_x_in;
                        n_pos_y   = i_y_in;
                        n_heading = i_theta_in;
                        n_speed   = i_v_in;
                        n_count   = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_acc   = i_accel;
                        n_rate  = i_turn_rate;
                        n_state = S_ROT;
                    end
                end
            end
            S_ROT: begin
                if (w_cres.done) begin
                    n_state = S_MX;
                end
            end
            S_MX: begin
                n_base  = signed'(w_prod[31:0]);
                n_state = S_MY;
            end
            S_MY: begin
                n_pos_x = sat32(33'(r_pos_x) + 33'(w_dpos));
                n_state = S_MH;
            end
            S_MH: begin
                n_pos_y = sat32(33'(r_pos_y) + 33'(w_dpos));
                n_state = S_MS;
            end
            S_MS: begin
                n_h     = 18'(r_heading) + 18'(w_dq12);
                n_state = S_MV;
            end
            S_MV: begin
                n_speed = sat16(18'(r_speed) + 18'(w_dq12));
                n_state = S_HWRAP;
            end
            S_HWRAP: begin
                if (r_h > PI_Q12) begin
                    n_h = r_h - TWO_PI_Q12;
                end else if (r_h < -PI_Q12) begin
                    n_h = r_h + TWO_PI_Q12;
                end else begin
                    n_heading = r_h[15:0];
                    n_count   = (r_count != 8'hFF) ? (r_count + 8'd1) : r_count;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid    = 1'b1;
                    n_x_out     = r_pos_x;
                    n_y_out     = r_pos_y;
                    n_theta_out = r_heading;
                    n_step_idx  = r_count;
                    n_is_last   = (r_count == r_horizon);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_step_time <= STEP_TIME_RST;
            r_horizon   <= HORIZON_RST;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_speed     <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_ovalid    <= n_ovalid;
            r_step_time <= n_step_time;
            r_horizon   <= n_horizon;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_heading   <= n_heading;
            r_speed     <= n_speed;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_rate      <= n_rate;
        r_base      <= n_base;
        r_h         <= n_h;
        r_cmd       <= n_cmd;
        r_x_out     <= n_x_out;
        r_y_out     <= n_y_out;
        r_theta_out <= n_theta_out;
        r_step_idx  <= n_step_idx;
        r_is_last   <= n_is_last;
    end

    assign o_out_valid  = r_ovalid;
    assign o_x_out      = r_x_out;
    assign o_y_out      = r_y_out;
    assign o_theta_out  = r_theta_out;
    assign o_step_index = r_step_idx;
    assign o_is_last    = r_is_last;

`ifndef SYNTHESIS
    // cordic finishes only while the sequencer waits for it
    a_cordic_done_in_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cres.done |-> (r_state == S_ROT))
        else $error("cordic done outside rotation wait");

    // heading is wrapped once a step is finished
    a_heading_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_cmd == CMD_STEP))
            |-> ((18'(r_heading) <= PI_Q12) && (18'(r_heading) >= -PI_Q12)))
        else $error("heading out of range after step");

    // start transfer clears the step count and goes straight to the result
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_START)) |=> ((r_state == S_DONE) && (r_count == 8'd0)))
        else $error("start transfer did not load pose");
`endif

endmodule

`default_nettype wire
